// ----- rtl/tapc_pkg.sv -----
// Shared types and constants for the two-axis PD coil controller.
// No dependencies; used by every module of the block.

package tapc_pkg;

    localparam int HALL_W      = 12;
    localparam int POS_W       = 13;
    localparam int DIFF_W      = 14;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 8;
    localparam int DUTY_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int WINDOW_DEF  = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [HALL_W-1:0] OFFSET_RST       = 12'd2048;
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST    = 16'd410;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST   = 16'd3840;
    localparam logic [HALL_W-1:0] ENABLE_LEVEL_RST = 12'd1500;

    localparam logic signed [DUTY_W-1:0] DUTY_MAX = 16'sh7FFF;
    localparam logic signed [DUTY_W-1:0] DUTY_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X     = 3'd0,
        REG_OFFSET_Y     = 3'd1,
        REG_GAIN_PROP    = 3'd2,
        REG_GAIN_DERIV   = 3'd3,
        REG_ENABLE_LEVEL = 3'd4
    } t_reg_idx;

    // stage load strobes handed from the top-level control to each axis
    typedef struct packed {
        logic acc;
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

endpackage

// ----- rtl/tapc_axis.sv -----
// One axis of the PD controller: position, derivative ring, running sum and
// the pipelined drive arithmetic. Depends on tapc_pkg.

module tapc_axis #(
    parameter int WINDOW = tapc_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tapc_pkg::t_pipe_ctl                 i_ctl,
    input  logic [tapc_pkg::HALL_W-1:0]         i_hall,
    input  logic [tapc_pkg::HALL_W-1:0]         i_offset,
    input  logic [tapc_pkg::GAIN_W-1:0]         i_gain_prop,
    input  logic [tapc_pkg::GAIN_W-1:0]         i_gain_deriv,
    output logic signed [tapc_pkg::DUTY_W-1:0]  o_drive
);
    import tapc_pkg::*;

    localparam int LW    = $clog2(WINDOW);
    localparam int SUM_W = DIFF_W + LW;
    localparam int PP_W  = GAIN_W + 1 + POS_W;
    localparam int PD_W  = GAIN_W + 1 + SUM_W;
    localparam int T_W   = PD_W + 2;
    localparam int XW    = DUTY_W + LW;
    localparam int SH    = XW + LW;
    localparam int MW    = XW + 1;
    localparam int Q_W   = DUTY_W + 1;

    // divide by 256*WINDOW: saturation limits, then shift and reciprocal
    localparam logic signed [T_W-1:0] WIN_S  = T_W'(WINDOW);
    localparam logic signed [T_W-1:0] HI_LIM = T_W'(64'sd8388608 * WINDOW);
    localparam logic signed [T_W-1:0] LO_LIM = T_W'(-64'sd8388864 * WINDOW);
    localparam longint RECIP_L = ((64'sd1 <<< SH) + WINDOW - 1) / WINDOW;
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic signed [POS_W-1:0]  w_pos, r_pos;
    logic signed [DIFF_W-1:0] w_diff, w_old, r_rd;
    logic signed [DIFF_W-1:0] r_ring [WINDOW];
    logic signed [SUM_W-1:0]  w_sum, r_sum;
    logic [LW-1:0]            r_idx, w_idx_nxt;
    logic [WINDOW-1:0]        r_vld;
    logic                     r_rd_vld;

    logic signed [PP_W-1:0]   r_pp;
    logic signed [PD_W-1:0]   r_pd;
    logic signed [T_W-1:0]    w_t, w_n, w_mag;
    logic                     r_neg, r_hi, r_lo;
    logic [XW-1:0]            r_x;
    logic [XW+MW-1:0]         w_prod;
    logic [Q_W-1:0]           w_q, w_qs;

    assign w_pos     = $signed({1'b0, i_hall}) - $signed({1'b0, i_offset});
    assign w_diff    = DIFF_W'(w_pos) - DIFF_W'(r_pos);
    assign w_old     = r_rd_vld ? r_rd : '0;
    assign w_sum     = r_sum - SUM_W'(w_old) + SUM_W'(w_diff);
    assign w_idx_nxt = (r_idx == LW'(WINDOW - 1)) ? '0 : r_idx + 1'b1;

    // ring: write the current slot, prefetch the slot the next item retires
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_ring[r_idx] <= w_diff;
            r_rd          <= r_ring[w_idx_nxt];
        end
    end

    // r_pos / r_sum double as the first pipeline stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= '0;
            r_idx    <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_ctl.acc) begin
            r_pos        <= w_pos;
            r_sum        <= w_sum;
            r_idx        <= w_idx_nxt;
            r_vld[r_idx] <= 1'b1;
            r_rd_vld     <= r_vld[w_idx_nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_pp <= PP_W'($signed({1'b0, i_gain_prop})) * PP_W'(r_pos);
            r_pd <= PD_W'($signed({1'b0, i_gain_deriv})) * PD_W'(r_sum);
        end
    end

    assign w_t   = T_W'(r_pp) * WIN_S + T_W'(r_pd);
    assign w_n   = -w_t;
    assign w_mag = w_n[T_W-1] ? -w_n : w_n;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_neg <= w_n[T_W-1];
            r_hi  <= (w_n >= HI_LIM);
            r_lo  <= (w_n <= LO_LIM);
            r_x   <= w_mag[GAIN_FRAC +: XW];
        end
    end

    // magnitude / WINDOW, exact for every r_x below 2**XW
    assign w_prod = (XW+MW)'(r_x) * (XW+MW)'(RECIP);
    assign w_q    = w_prod[SH +: Q_W];
    assign w_qs   = r_neg ? (Q_W'(0) - w_q) : w_q;

    always_comb begin
        if (r_hi) begin
            o_drive = DUTY_MAX;
        end else if (r_lo) begin
            o_drive = DUTY_MIN;
        end else begin
            o_drive = $signed(w_qs[DUTY_W-1:0]);
        end
    end

endmodule

// ----- rtl/two_axis_pd_coil_controller.sv -----
// Two-axis PD coil controller: configuration registers, pipeline control and
// the coil duty output register. Depends on tapc_pkg and tapc_axis.
//
// Usage:
//   Input stream (s_axis): one transfer per control tick carrying the X, Y and
//   height Hall samples. Output stream (m_axis): one transfer per input item
//   with the four coil duties and the coil enable flag.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 offset_x, 1 offset_y, 2 gain_prop, 3 gain_deriv, 4 enable_level);
//   other indexes are ignored. Write only while the pipeline is empty.
//   Pipeline: four registered stages (state update, gain multipliers, sum and
//   limit, reciprocal divide); the result is presented from the last of them.
//   Throughput: one item per cycle while m_axis accepts; every stage moves
//   independently, so bubbles are squeezed out.
//   Stall: while m_axis is held off the output register keeps its data and
//   the stages behind it keep filling; s_axis_tready drops once all are full.
//   Reset: synchronous, active low. Registers return to their defaults, the
//   previous positions and sums clear, the difference ring entries are marked invalid, the pipeline empties.

module two_axis_pd_coil_controller #(
    parameter int WINDOW = tapc_pkg::WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // [11:0] hall_x, [23:12] hall_y, [35:24] hall_h, [39:36] zero
    input  logic [tapc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c, [63:48] duty_d,
    // [64] coil_enable, [71:65] zero
    output logic [tapc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [tapc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tapc_pkg::CFG_W-1:0]         i_cfg_data
);
    import tapc_pkg::*;

    logic [HALL_W-1:0] r_offset_x, r_offset_y, r_enable_level;
    logic [GAIN_W-1:0] r_gain_prop, r_gain_deriv;

    logic r_v1, r_v2, r_v3, r_vo;
    logic r_en1, r_en2, r_en3, r_coil_en;
    logic w_rdy_o, w_rdy3, w_rdy2, w_rdy1;
    logic w_ld_o, w_ld3, w_ld2, w_acc;
    t_pipe_ctl w_ctl;

    logic [HALL_W-1:0] w_hall_x, w_hall_y, w_hall_h;
    logic signed [DUTY_W-1:0] w_drv_x, w_drv_y;
    logic signed [DUTY_W-1:0] r_duty_a, r_duty_b, r_duty_c, r_duty_d;

    function automatic logic signed [DUTY_W-1:0] f_neg_sat(
        input logic signed [DUTY_W-1:0] v
    );
        logic signed [DUTY_W-1:0] res;
        if (v == DUTY_MIN) begin
            res = DUTY_MAX;
        end else begin
            res = -v;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x     <= OFFSET_RST;
            r_offset_y     <= OFFSET_RST;
            r_gain_prop    <= GAIN_PROP_RST;
            r_gain_deriv   <= GAIN_DERIV_RST;
            r_enable_level <= ENABLE_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_OFFSET_X:     r_offset_x     <= i_cfg_data[HALL_W-1:0];
                REG_OFFSET_Y:     r_offset_y     <= i_cfg_data[HALL_W-1:0];
                REG_GAIN_PROP:    r_gain_prop    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV:   r_gain_deriv   <= i_cfg_data[GAIN_W-1:0];
                REG_ENABLE_LEVEL: r_enable_level <= i_cfg_data[HALL_W-1:0];
                default: ;
            endcase
        end
    end

    // each stage loads when its successor is empty or moving on
    assign w_rdy_o = !r_vo | i_m_axis_tready;
    assign w_ld_o  = r_v3 & w_rdy_o;
    assign w_rdy3  = !r_v3 | w_rdy_o;
    assign w_ld3   = r_v2 & w_rdy3;
    assign w_rdy2  = !r_v2 | w_rdy3;
    assign w_ld2   = r_v1 & w_rdy2;
    assign w_rdy1  = !r_v1 | w_rdy2;
    assign w_acc   = i_s_axis_tvalid & w_rdy1;

    assign o_s_axis_tready = w_rdy1;
    assign w_ctl = '{acc: w_acc, ld2: w_ld2, ld3: w_ld3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= w_acc  | (r_v1 & !w_ld2);
            r_v2 <= w_ld2  | (r_v2 & !w_ld3);
            r_v3 <= w_ld3  | (r_v3 & !w_ld_o);
            r_vo <= w_ld_o | (r_vo & !i_m_axis_tready);
        end
    end

    assign w_hall_x = i_s_axis_tdata[HALL_W-1:0];
    assign w_hall_y = i_s_axis_tdata[2*HALL_W-1:HALL_W];
    assign w_hall_h = i_s_axis_tdata[3*HALL_W-1:2*HALL_W];

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_en1 <= (w_hall_h < r_enable_level);
        end
        if (w_ld2) begin
            r_en2 <= r_en1;
        end
        if (w_ld3) begin
            r_en3 <= r_en2;
        end
    end

    tapc_axis #(.WINDOW(WINDOW)) u_axis_x (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_hall       (w_hall_x),
        .i_offset     (r_offset_x),
        .i_gain_prop  (r_gain_prop),
        .i_gain_deriv (r_gain_deriv),
        .o_drive      (w_drv_x)
    );

    tapc_axis #(.WINDOW(WINDOW)) u_axis_y (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_hall       (w_hall_y),
        .i_offset     (r_offset_y),
        .i_gain_prop  (r_gain_prop),
        .i_gain_deriv (r_gain_deriv),
        .o_drive      (w_drv_y)
    );

    // coils A/B take the negated drive, C/D the drive itself
    always_ff @(posedge i_clk) begin
        if (w_ld_o) begin
            r_duty_a  <= f_neg_sat(w_drv_x);
            r_duty_b  <= f_neg_sat(w_drv_y);
            r_duty_c  <= w_drv_x;
            r_duty_d  <= w_drv_y;
            r_coil_en <= r_en3;
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {7'b0, r_coil_en, r_duty_d, r_duty_c, r_duty_b, r_duty_a};

endmodule

// ----- rtl/tapc_sva.sv -----
// Port-level checks for two_axis_pd_coil_controller, attached with bind.
// Depends on tapc_pkg for port widths.

module tapc_sva (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic [tapc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // coil A mirrors coil C, the most negative duty mapping to the maximum
    a_mirror_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[47:32] == 16'h8000 && o_m_axis_tdata[15:0] == 16'h7FFF) ||
            (o_m_axis_tdata[47:32] != 16'h8000 &&
             16'(o_m_axis_tdata[15:0] + o_m_axis_tdata[47:32]) == 16'h0000))
        else $error("coil A is not the negated coil C duty");

    a_mirror_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[63:48] == 16'h8000 && o_m_axis_tdata[31:16] == 16'h7FFF) ||
            (o_m_axis_tdata[63:48] != 16'h8000 &&
             16'(o_m_axis_tdata[31:16] + o_m_axis_tdata[63:48]) == 16'h0000))
        else $error("coil B is not the negated coil D duty");

endmodule

bind two_axis_pd_coil_controller tapc_sva u_tapc_sva (.*);

// ----- tb/sv/tapc_duty_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the two-axis PD coil controller: follows the sample, duty and
// register-write channels, predicts each coil duty transfer and compares it.
// Depends on tapc_pkg.

module tapc_duty_checker
    import tapc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // [11:0] hall_x, [23:12] hall_y, [35:24] hall_h, [39:36] zero
    input  logic [IN_TDATA_W-1:0]  i_smp_tdata,
    input  logic                   i_smp_tvalid,
    input  logic                   i_smp_tready,
    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c, [63:48] duty_d,
    // [64] coil_enable, [71:65] zero
    input  logic [OUT_TDATA_W-1:0] i_duty_tdata,
    input  logic                   i_duty_tvalid,
    input  logic                   i_duty_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_mismatches,
    output int                     o_pending
);

    localparam int WIN    = WINDOW_DEF;
    localparam int SLOT_W = $clog2(WIN);
    localparam int SUM_W  = DIFF_W + SLOT_W + 1;

    typedef struct packed {
        logic [HALL_W-1:0] hall_h;
        logic [HALL_W-1:0] hall_y;
        logic [HALL_W-1:0] hall_x;
    } hall_item_t;

    typedef struct packed {
        logic                     coil_enable;
        logic signed [DUTY_W-1:0] duty_d;
        logic signed [DUTY_W-1:0] duty_c;
        logic signed [DUTY_W-1:0] duty_b;
        logic signed [DUTY_W-1:0] duty_a;
    } coil_duties_t;

    logic [HALL_W-1:0]        off_x, off_y, en_level;
    logic [GAIN_W-1:0]        kp, kd;
    logic signed [POS_W-1:0]  prev_x, prev_y;
    logic signed [DIFF_W-1:0] ring_x [WIN];
    logic signed [DIFF_W-1:0] ring_y [WIN];
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic [SLOT_W-1:0]        slot;

    coil_duties_t pending_duties [$];
    int           mismatches = 0;

    function automatic logic signed [DUTY_W-1:0] clamp_duty(longint v);
        if (v > longint'(DUTY_MAX)) return DUTY_MAX;
        if (v < longint'(DUTY_MIN)) return DUTY_MIN;
        return v[DUTY_W-1:0];
    endfunction

    // -(kp*pos*WIN + kd*sum) / (256*WIN), one division truncating toward zero
    function automatic logic signed [DUTY_W-1:0] axis_drive(logic signed [POS_W-1:0] pos,
                                                            logic signed [SUM_W-1:0] sum);
        longint t;
        t = longint'(kp) * longint'(pos) * longint'(WIN) + longint'(kd) * longint'(sum);
        return clamp_duty((-t) / (longint'(1 << GAIN_FRAC) * longint'(WIN)));
    endfunction

    function automatic coil_duties_t predict_coil_duties(hall_item_t s);
        logic signed [POS_W-1:0]  px, py;
        logic signed [DIFF_W-1:0] dx, dy;
        logic signed [DUTY_W-1:0] drv_x, drv_y;
        coil_duties_t             r;
        px = $signed({1'b0, s.hall_x}) - $signed({1'b0, off_x});
        py = $signed({1'b0, s.hall_y}) - $signed({1'b0, off_y});
        dx = DIFF_W'(px) - DIFF_W'(prev_x);
        dy = DIFF_W'(py) - DIFF_W'(prev_y);
        sum_x = sum_x - SUM_W'(ring_x[slot]) + SUM_W'(dx);
        sum_y = sum_y - SUM_W'(ring_y[slot]) + SUM_W'(dy);
        ring_x[slot] = dx;
        ring_y[slot] = dy;
        prev_x = px;
        prev_y = py;
        slot = (slot == SLOT_W'(WIN - 1)) ? '0 : slot + 1'b1;
        drv_x = axis_drive(px, sum_x);
        drv_y = axis_drive(py, sum_y);
        r.duty_a      = clamp_duty(-longint'(drv_x));
        r.duty_b      = clamp_duty(-longint'(drv_y));
        r.duty_c      = drv_x;
        r.duty_d      = drv_y;
        r.coil_enable = (s.hall_h < en_level);
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        coil_duties_t got, want;
        int           k;
        if (!i_rst_n) begin
            off_x    = OFFSET_RST;
            off_y    = OFFSET_RST;
            kp       = GAIN_PROP_RST;
            kd       = GAIN_DERIV_RST;
            en_level = ENABLE_LEVEL_RST;
            prev_x   = '0;
            prev_y   = '0;
            for (k = 0; k < WIN; k++) begin
                ring_x[k] = '0;
                ring_y[k] = '0;
            end
            sum_x = '0;
            sum_y = '0;
            slot  = '0;
            pending_duties.delete();
        end else begin
            // drain before fill: a transfer out can never belong to this edge's sample
            if (i_duty_tvalid && i_duty_tready) begin
                got = i_duty_tdata[$bits(coil_duties_t)-1:0];
                if (pending_duties.size() == 0) begin
                    $display("%0t: unexpected duty transfer %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_duties.pop_front();
                    check_field("duty_a", longint'(want.duty_a), longint'(got.duty_a));
                    check_field("duty_b", longint'(want.duty_b), longint'(got.duty_b));
                    check_field("duty_c", longint'(want.duty_c), longint'(got.duty_c));
                    check_field("duty_d", longint'(want.duty_d), longint'(got.duty_d));
                    check_field("coil_enable", longint'(want.coil_enable),
                                longint'(got.coil_enable));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_X:     off_x    = i_cfg_data[HALL_W-1:0];
                    REG_OFFSET_Y:     off_y    = i_cfg_data[HALL_W-1:0];
                    REG_GAIN_PROP:    kp       = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_DERIV:   kd       = i_cfg_data[GAIN_W-1:0];
                    REG_ENABLE_LEVEL: en_level = i_cfg_data[HALL_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp_tvalid && i_smp_tready)
                pending_duties.push_back(
                    predict_coil_duties(i_smp_tdata[$bits(hall_item_t)-1:0]));
        end
        o_pending    <= pending_duties.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- tb/sv/tb_two_axis_pd_coil_controller.sv -----
`timescale 1ns / 100ps
// Top of the coil controller testbench: clock, reset, sample and duty stream
// drivers, register writes and the verdict. Depends on tapc_pkg, the block and
// tapc_duty_checker.

module tb_two_axis_pd_coil_controller;
    import tapc_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF     = 120;
    localparam int HALL_MAX     = (1 << HALL_W) - 1;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_MID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI  = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    wire                    o_s_axis_tready;
    wire  [OUT_TDATA_W-1:0] o_m_axis_tdata;
    wire                    o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx       = '0;
    logic [CFG_W-1:0]       i_cfg_data      = '0;

    int mismatches;
    int pending;
    int quiet_cycles = 0;

    // register copies, only to steer the stimulus
    logic [HALL_W-1:0] cfg_off_x  = OFFSET_RST;
    logic [HALL_W-1:0] cfg_off_y  = OFFSET_RST;
    logic [HALL_W-1:0] cfg_level  = ENABLE_LEVEL_RST;
    logic [HALL_W-1:0] last_x     = OFFSET_RST;
    logic [HALL_W-1:0] last_y     = OFFSET_RST;
    bit                src_calm   = 1'b0;
    int                samples_in = 0;

    two_axis_pd_coil_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    tapc_duty_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_smp_tdata   (i_s_axis_tdata),
        .i_smp_tvalid  (i_s_axis_tvalid),
        .i_smp_tready  (o_s_axis_tready),
        .i_duty_tdata  (o_m_axis_tdata),
        .i_duty_tvalid (o_m_axis_tvalid),
        .i_duty_tready (i_m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // duty sink: random stalls, calm stretches, and two long hold-offs that back
    // the pipeline up into the sample stream
    initial begin : duty_sink
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (i_rst_n);
        forever begin
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (taken == 200 || taken == 800)
                stall = HOLD_OFF;
            else if (calm)
                stall = 0;
            else
                stall = $urandom_range(0, 11);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            taken++;
        end
    end

    task automatic push_sample(input logic [HALL_W-1:0] hx, input logic [HALL_W-1:0] hy,
                               input logic [HALL_W-1:0] hh);
        int gap;
        if (samples_in % 40 == 0)
            src_calm = ($urandom_range(0, 2) == 0);
        gap = src_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= {4'b0, hh, hy, hx};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        samples_in++;
    endtask

    // let the pipeline empty before touching the registers
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_OFFSET_X:     cfg_off_x = value[HALL_W-1:0];
            REG_OFFSET_Y:     cfg_off_y = value[HALL_W-1:0];
            REG_ENABLE_LEVEL: cfg_level = value[HALL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
                                input logic [CFG_W-1:0] gp, input logic [CFG_W-1:0] gd,
                                input logic [CFG_W-1:0] lvl);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_GAIN_PROP, gp);
        write_reg(REG_GAIN_DERIV, gd);
        write_reg(REG_ENABLE_LEVEL, lvl);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [HALL_W-1:0] clamp_hall(int v);
        if (v < 0) return '0;
        if (v > HALL_MAX) return HALL_W'(HALL_MAX);
        return v[HALL_W-1:0];
    endfunction

    // mostly slow drift or steps near the centre so the drive stays out of saturation, plus jumps and rails
    function automatic logic [HALL_W-1:0] next_hall(logic [HALL_W-1:0] centre,
                                                    logic [HALL_W-1:0] prev);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return clamp_hall(int'(prev) + int'($urandom_range(0, 80)) - 40);
        if (pick < 7)
            return HALL_W'($urandom_range(0, HALL_MAX));
        if (pick < 9)
            return clamp_hall(int'(centre) + int'($urandom_range(0, 200)) - 100);
        return $urandom_range(0, 1) ? HALL_W'(HALL_MAX) : '0;
    endfunction

    function automatic logic [HALL_W-1:0] next_height();
        if ($urandom_range(0, 1))
            return HALL_W'($urandom_range(0, HALL_MAX));
        return clamp_hall(int'(cfg_level) + int'($urandom_range(0, 8)) - 4);
    endfunction

    task automatic run_random(input int count);
        logic [HALL_W-1:0] hx, hy;
        int                n;
        for (n = 0; n < count; n++) begin
            hx = next_hall(cfg_off_x, last_x);
            hy = next_hall(cfg_off_y, last_y);
            push_sample(hx, hy, next_height());
            last_x = hx;
            last_y = hy;
        end
    endtask

    task automatic program_random();
        program_regs(CFG_W'($urandom_range(0, HALL_MAX)), CFG_W'($urandom_range(0, HALL_MAX)),
                     CFG_W'($urandom_range(0, 1023)), CFG_W'($urandom_range(0, 8191)),
                     CFG_W'($urandom_range(0, HALL_MAX)));
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings; first tick sees zero previous position, then the
        // height threshold either side and rail-to-rail steps
        push_sample(12'd2048, 12'd2048, 12'd0);
        push_sample(12'd4095, 12'd0, 12'd1499);
        push_sample(12'd0, 12'd4095, 12'd1500);
        push_sample(12'd4095, 12'd4095, 12'd1501);
        push_sample(12'd0, 12'd0, 12'd4095);
        push_sample(12'd4095, 12'd0, 12'd0);
        push_sample(12'd4095, 12'd0, 12'd0);
        push_sample(12'd1, 12'd4094, 12'd1);
        push_sample(12'd2048, 12'd2048, 12'd2048);
        drain();

        // full gains: drive pinned at both rails, minimum negated on coils A and B
        program_regs(16'd0, 16'd4095, 16'hFFFF, 16'hFFFF, 16'd4095);
        push_sample(12'd4095, 12'd0, 12'd4094);
        push_sample(12'd4095, 12'd0, 12'd4095);
        push_sample(12'd0, 12'd4095, 12'd0);
        push_sample(12'd0, 12'd4095, 12'd0);
        push_sample(12'd1, 12'd4094, 12'd1);
        push_sample(12'd4095, 12'd0, 12'd2048);
        push_sample(12'd0, 12'd4095, 12'd4095);
        push_sample(12'd2048, 12'd2048, 12'd100);
        run_random(230);
        drain();

        // zero gains and the opposite offsets: all duties zero, coils never enabled
        program_regs(16'd4095, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(150);
        drain();

        // unmapped indexes are dropped, excess data bits are masked
        write_reg(REG_NONE_LO, 16'hFFFF);
        write_reg(REG_NONE_MID, 16'h0000);
        write_reg(REG_NONE_HI, 16'h5A5A);
        program_regs(16'hF800, 16'hFFFF, 16'd256, 16'd1, 16'hF5DC);
        run_random(230);
        drain();

        program_random();
        run_random(260);
        drain();

        program_random();
        run_random(260);
        drain();

        program_regs(CFG_W'(OFFSET_RST), CFG_W'(OFFSET_RST), GAIN_PROP_RST, GAIN_DERIV_RST,
                     CFG_W'(ENABLE_LEVEL_RST));
        run_random(250);
        drain();

        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
